// ===== rtl/dtc_pkg.sv =====
// Shared constants, register codes and pipeline types of the tone curve table generator.
package dtc_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 1024;
  localparam int unsigned IDX_W          = 10;
  localparam int unsigned LEVEL_W        = 16;
  localparam int unsigned Q16_W          = 17;
  localparam int unsigned SCALE_W        = 15;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_GAMMA = 3'd0,
    REG_SHADOW    = 3'd1,
    REG_HIGHLIGHT = 3'd2,
    REG_SLOPE     = 3'd3,
    REG_OFFSET    = 3'd4,
    REG_SCALE_R   = 3'd5,
    REG_SCALE_G   = 3'd6,
    REG_SCALE_B   = 3'd7
  } cfg_reg_e;

  // Q30 values of 2^(2^-k), k = 1..16.
  localparam logic [30:0] EXP2_STEPS [16] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
    31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
    31'd1075196444, 31'd1074468888, 31'd1074105294, 31'd1073923544,
    31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
  };

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } ctl_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [Q16_W-1:0] level;
  } pow_xfer_t;

endpackage

// ===== rtl/dtc_in_if.sv =====
// Input channel of the tone curve table generator: one table position per transfer.
interface dtc_in_if import dtc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] ramp_index;

  modport source (output valid, output ramp_index, input ready);
  modport sink (input valid, input ramp_index, output ready);
endinterface

// ===== rtl/dtc_out_if.sv =====
// Output channel of the tone curve table generator: one table entry per transfer.
interface dtc_out_if import dtc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   entry_index;
  logic [LEVEL_W-1:0] red_level;
  logic [LEVEL_W-1:0] green_level;
  logic [LEVEL_W-1:0] blue_level;

  modport source (output valid, output entry_index, output red_level, output green_level,
                  output blue_level, input ready);
  modport sink (input valid, input entry_index, input red_level, input green_level,
                input blue_level, output ready);
endinterface

// ===== rtl/dtc_power.sv =====
// Pipelined power unit: Q16 level raised to the reciprocal gamma via log2 and exp2 stages.
module dtc_power import dtc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic [15:0] inverse_gamma_i,
  input  pow_xfer_t req_i,
  output pow_xfer_t rsp_o
);

  typedef struct packed {
    ctl_t        ctl;
    logic        zero;
    logic [4:0]  lead;
    logic [30:0] mant;
    logic [15:0] frac;
  } log_st_t;

  typedef struct packed {
    ctl_t        ctl;
    logic        zero;
    logic [22:0] expo;
  } exp_st_t;

  typedef struct packed {
    ctl_t        ctl;
    logic        zero;
    logic        kill;
    logic [7:0]  sh;
    logic [15:0] frac;
    logic [30:0] mant;
  } pw_st_t;

  log_st_t   log_d;
  log_st_t   log_q [17];
  exp_st_t   exp_d, exp_q;
  pw_st_t    pw_init;
  pw_st_t    pw_q [16];
  pow_xfer_t rsp_d, rsp_q;

  logic [4:0]  lead;
  logic [20:0] neg_log;
  logic [36:0] expo_prod;
  logic [6:0]  ki;
  logic [15:0] ef;
  logic [41:0] round_sum;

  // Leading one and normalization of the input to a Q30 mantissa in [1, 2).
  always_comb begin
    lead = '0;
    for (int b = 0; b < Q16_W; b++) begin
      if (req_i.level[b]) begin
        lead = 5'(b);
      end
    end
    log_d.ctl  = req_i.ctl;
    log_d.zero = (req_i.level == '0);
    log_d.lead = lead;
    log_d.mant = 31'(req_i.level) << (5'd30 - lead);
    log_d.frac = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_q[0].ctl.valid <= 1'b0;
    end else if (en_i) begin
      log_q[0] <= log_d;
    end
  end

  // One fraction bit of log2 per stage by squaring the mantissa.
  for (genvar k = 0; k < 16; k++) begin : g_log
    logic [61:0] sq;
    logic [31:0] sq_hi;
    log_st_t     nx;

    always_comb begin
      sq       = 62'(log_q[k].mant) * 62'(log_q[k].mant);
      sq_hi    = sq[61:30];
      nx       = log_q[k];
      nx.frac  = {log_q[k].frac[14:0], sq_hi[31]};
      nx.mant  = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        log_q[k+1].ctl.valid <= 1'b0;
      end else if (en_i) begin
        log_q[k+1] <= nx;
      end
    end
  end

  // Negated log2 times the reciprocal gamma, rounded to Q16.
  always_comb begin
    neg_log   = {5'(5'd16 - log_q[16].lead), 16'h0000} - 21'(log_q[16].frac);
    expo_prod = 37'(neg_log) * 37'(inverse_gamma_i);
    exp_d.ctl  = log_q[16].ctl;
    exp_d.zero = log_q[16].zero;
    exp_d.expo = 23'((expo_prod + 37'd8192) >> 14);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q.ctl.valid <= 1'b0;
    end else if (en_i) begin
      exp_q <= exp_d;
    end
  end

  // Split the exponent into its integer shift and the fraction for the exp2 chain.
  always_comb begin
    ki            = exp_q.expo[22:16];
    ef            = exp_q.expo[15:0];
    pw_init.ctl   = exp_q.ctl;
    pw_init.zero  = exp_q.zero;
    pw_init.kill  = (ki > 7'd40);
    pw_init.sh    = 8'(ki) + ((ef == '0) ? 8'd14 : 8'd15);
    pw_init.frac  = 16'(17'h10000 - 17'(ef));
    pw_init.mant  = 31'h4000_0000;
  end

  for (genvar k = 0; k < 16; k++) begin : g_exp
    pw_st_t      src;
    pw_st_t      nx;
    logic [61:0] prod;
    logic [61:0] rnd;

    if (k == 0) begin : g_first
      assign src = pw_init;
    end else begin : g_next
      assign src = pw_q[k-1];
    end

    always_comb begin
      prod = 62'(src.mant) * 62'(EXP2_STEPS[k]);
      rnd  = prod + (62'd1 << 29);
      nx   = src;
      if (src.frac[15-k]) begin
        nx.mant = rnd[60:30];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pw_q[k].ctl.valid <= 1'b0;
      end else if (en_i) begin
        pw_q[k] <= nx;
      end
    end
  end

  // Final right shift with rounding half up; far too small results go to zero.
  always_comb begin
    round_sum = 42'(pw_q[15].mant) + (42'd1 << (pw_q[15].sh - 8'd1));
    rsp_d.ctl = pw_q[15].ctl;
    if (pw_q[15].zero || pw_q[15].kill || (pw_q[15].sh > 8'd40)) begin
      rsp_d.level = '0;
    end else begin
      rsp_d.level = Q16_W'(round_sum >> pw_q[15].sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_q.ctl.valid <= 1'b0;
    end else if (en_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== rtl/display_tone_curve_lut.sv =====
// Top level of the tone curve table generator: normalize, power, bends, slope/offset, scales.
//
// The block turns a table position into the red, green and blue entries of a display gamma
// table. It takes one position per clock cycle and delivers one entry per cycle while the sink
// keeps taking entries; every entry passes through the normalization stages, the power unit
// (whose 16 log2 squaring stages and 16 exp2 multiply stages set its depth), the tone shaping
// stages and one output register. A two-entry output buffer sits at the end, so positions
// keep flowing while one finished entry waits to be taken; when a second one is parked there
// the whole pipeline holds until the sink takes a transfer. Settings are written through the
// plain register port and should only change while no entry is in flight. Positions beyond
// the end of the table count as full scale.
module display_tone_curve_lut import dtc_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dtc_in_if.sink                in_i,
  dtc_out_if.source             out_o
);

  localparam int unsigned DENOM    = TABLE_SIZE - 1;
  localparam int unsigned HALF_DEN = DENOM / 2;
  localparam int unsigned RECIP_SH = 10;
  localparam longint unsigned RECIP = (64'd1 << (16 + RECIP_SH)) / DENOM;
  localparam int unsigned RECIP_W  = $clog2(RECIP + 1);
  localparam int unsigned PROD1_W  = IDX_W + RECIP_W;
  localparam int unsigned NUM_W    = IDX_W + 17;
  localparam logic signed [35:0] FIVE_Q30 = 36'sd5368709120;
  localparam logic [55:0] HALF_FIVE_Q30   = 56'd2684354560;
  localparam logic [48:0] RECIP5          = 49'd26843545;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } entry_t;

  // Settings.
  logic [15:0]        inv_gamma_q;
  logic signed [15:0] shadow_q;
  logic signed [15:0] highlight_q;
  logic [15:0]        slope_q;
  logic signed [15:0] offset_q;
  logic [SCALE_W-1:0] scale_r_q, scale_g_q, scale_b_q;

  logic pipe_en;
  ctl_t pre_q [2];
  ctl_t post_q [11];
  pow_xfer_t pow_req_q, pow_rsp;

  // Normalization stages.
  logic [IDX_W-1:0]   pos_d, pos_q;
  logic [PROD1_W-1:0] prod1_q;
  logic [Q16_W-1:0]   q0_d, q0_q;
  logic [NUM_W-1:0]   num_d, num_q, qd_d, qd_q, rem;
  logic [Q16_W-1:0]   x_d;

  // Tone stages.
  logic [Q16_W-1:0]   y1_q, u1_q, dark_q, light1_q, u1_d;
  logic signed [33:0] sd;
  logic               spos;
  logic signed [35:0] opa_d, opa_q;
  logic [18:0]        opb_d, opb_q;
  logic [Q16_W-1:0]   y2_q, light2_q, y3_q, light3_q, y4_q, light4_q;
  logic               spos2_q, spos3_q, spos4_q;
  logic signed [55:0] n3_d, n3_q;
  logic [55:0]        mag3;
  logic [23:0]        a4_d, a4_q;
  logic [48:0]        p4;
  logic [21:0]        q4_d, q4_q;
  logic               neg4_q;
  logic [23:0]        rem5;
  logic [21:0]        q5;
  logic signed [22:0] res5, v5_d, v5_q;
  logic [Q16_W-1:0]   light5_q;
  logic signed [33:0] hl;
  logic               hpos;
  logic signed [35:0] opa2_d, opa2_q;
  logic signed [23:0] opb2_d, opb2_q;
  logic signed [22:0] v6_q, v7_q;
  logic               hpos6_q, hpos7_q;
  logic signed [59:0] n7_d, n7_q;
  logic [59:0]        mag7;
  logic [23:0]        q8;
  logic signed [24:0] res8, v8;
  logic [Q16_W-1:0]   v8_d, v8_q;
  logic [32:0]        pz;
  logic signed [34:0] z9;
  logic [29:0]        z9_d, z9_q;
  logic [44:0]        wr_p, wg_p, wb_p;
  logic [43:0]        wr_d, wg_d, wb_d, wr_q, wg_q, wb_q;
  logic [59:0]        tr, tg, tb;
  logic [LEVEL_W-1:0] lr_q, lg_q, lb_q;

  // Output buffer.
  logic   out_vld_q, skid_vld_q, fire_in;
  entry_t out_q, skid_q, last_entry;

  // Register writes; unknown indexes cannot occur with a three-bit index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_gamma_q <= 16'd16384;
      shadow_q    <= '0;
      highlight_q <= '0;
      slope_q     <= 16'd8192;
      offset_q    <= '0;
      scale_r_q   <= SCALE_W'(16384);
      scale_g_q   <= SCALE_W'(16384);
      scale_b_q   <= SCALE_W'(16384);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_INV_GAMMA: inv_gamma_q <= cfg_data_i;
        REG_SHADOW:    shadow_q    <= cfg_data_i;
        REG_HIGHLIGHT: highlight_q <= cfg_data_i;
        REG_SLOPE:     slope_q     <= cfg_data_i;
        REG_OFFSET:    offset_q    <= cfg_data_i;
        REG_SCALE_R:   scale_r_q   <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE_G:   scale_g_q   <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE_B:   scale_b_q   <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one unless the output buffer has parked an entry.
  assign pipe_en   = !skid_vld_q;
  assign in_i.ready = pipe_en;

  // Position to Q16: round(pos * 65536 / (size - 1)) by reciprocal estimate and correction.
  always_comb begin
    pos_d = (32'(in_i.ramp_index) > DENOM) ? IDX_W'(DENOM) : in_i.ramp_index;
    q0_d  = Q16_W'(prod1_q >> RECIP_SH);
    num_d = {pos_q, 16'h0000} + NUM_W'(HALF_DEN);
    qd_d  = NUM_W'(NUM_W'(q0_d) * NUM_W'(DENOM));
    rem   = num_q - qd_q;
    if (rem >= NUM_W'(2 * DENOM)) begin
      x_d = q0_q + Q16_W'(2);
    end else if (rem >= NUM_W'(DENOM)) begin
      x_d = q0_q + Q16_W'(1);
    end else begin
      x_d = q0_q;
    end
  end

  dtc_power u_power (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (pipe_en),
    .inverse_gamma_i (inv_gamma_q),
    .req_i           (pow_req_q),
    .rsp_o           (pow_rsp)
  );

  // Shadow and highlight bends, the slope and offset, and the channel scales.
  always_comb begin
    u1_d = Q16_W'(18'h10000 - 18'(pow_rsp.level));

    sd    = 34'(shadow_q) * 34'($signed({1'b0, dark_q}));
    spos  = (shadow_q > 16'sd0);
    opa_d = spos ? 36'(sd) : FIVE_Q30 + (36'(sd) <<< 2);
    opb_d = spos ? 19'(19'(u1_q) * 19'd3) : 19'(y1_q);

    n3_d = 56'(opa_q) * 56'($signed({1'b0, opb_q}));

    mag3 = n3_q[55] ? 56'(-n3_q) : 56'(n3_q);
    a4_d = 24'((mag3 + HALF_FIVE_Q30) >> 30);
    p4   = 49'(a4_d) * RECIP5;
    q4_d = 22'(p4 >> 27);

    rem5 = a4_q - 24'(24'(q4_q) * 24'd5);
    q5   = (rem5 >= 24'd5) ? q4_q + 22'd1 : q4_q;
    res5 = neg4_q ? -$signed({1'b0, q5}) : $signed({1'b0, q5});
    v5_d = spos4_q ? $signed({6'b0, y4_q}) + res5 : res5;

    hl     = 34'(highlight_q) * 34'($signed({1'b0, light5_q}));
    hpos   = (highlight_q > 16'sd0);
    opa2_d = hpos ? 36'(hl) : 36'sd2147483648 + 36'(hl);
    opb2_d = hpos ? 24'sd65536 - 24'(v5_q) : 24'(v5_q);

    n7_d = 60'(opa2_q) * 60'(opb2_q);

    mag7 = n7_q[59] ? 60'(-n7_q) : 60'(n7_q);
    q8   = 24'((mag7 + (60'd1 << 30)) >> 31);
    res8 = n7_q[59] ? -$signed({1'b0, q8}) : $signed({1'b0, q8});
    v8   = hpos7_q ? 25'(v7_q) + res8 : res8;
    if (v8 < 25'sd0) begin
      v8_d = '0;
    end else if (v8 > 25'sd65536) begin
      v8_d = Q16_W'(65536);
    end else begin
      v8_d = Q16_W'(v8);
    end

    pz = 33'(slope_q) * 33'(v8_q);
    z9 = $signed({2'b00, pz}) + (35'(offset_q) <<< 15);
    if (z9 < 35'sd0) begin
      z9_d = '0;
    end else if (z9 > 35'sd536870912) begin
      z9_d = 30'h2000_0000;
    end else begin
      z9_d = 30'(z9);
    end

    wr_p = 45'(z9_q) * 45'(scale_r_q);
    wg_p = 45'(z9_q) * 45'(scale_g_q);
    wb_p = 45'(z9_q) * 45'(scale_b_q);
    wr_d = (wr_p > (45'd1 << 43)) ? (44'd1 << 43) : 44'(wr_p);
    wg_d = (wg_p > (45'd1 << 43)) ? (44'd1 << 43) : 44'(wg_p);
    wb_d = (wb_p > (45'd1 << 43)) ? (44'd1 << 43) : 44'(wb_p);

    // Times 65535 as a shift and a subtract, rounded at 2^-43.
    tr = {wr_q, 16'h0000} - 60'(wr_q) + (60'd1 << 42);
    tg = {wg_q, 16'h0000} - 60'(wg_q) + (60'd1 << 42);
    tb = {wb_q, 16'h0000} - 60'(wb_q) + (60'd1 << 42);
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pos_q   <= pos_d;
      prod1_q <= PROD1_W'(pos_d) * PROD1_W'(RECIP);
      q0_q    <= q0_d;
      num_q   <= num_d;
      qd_q    <= qd_d;

      y1_q     <= pow_rsp.level;
      u1_q     <= u1_d;
      dark_q   <= Q16_W'((34'(u1_d) * 34'(u1_d) + 34'd32768) >> 16);
      light1_q <= Q16_W'((34'(pow_rsp.level) * 34'(pow_rsp.level) + 34'd32768) >> 16);

      opa_q    <= opa_d;
      opb_q    <= opb_d;
      spos2_q  <= spos;
      y2_q     <= y1_q;
      light2_q <= light1_q;

      n3_q     <= n3_d;
      spos3_q  <= spos2_q;
      y3_q     <= y2_q;
      light3_q <= light2_q;

      a4_q     <= a4_d;
      q4_q     <= q4_d;
      neg4_q   <= n3_q[55];
      spos4_q  <= spos3_q;
      y4_q     <= y3_q;
      light4_q <= light3_q;

      v5_q     <= v5_d;
      light5_q <= light4_q;

      opa2_q  <= opa2_d;
      opb2_q  <= opb2_d;
      v6_q    <= v5_q;
      hpos6_q <= hpos;

      n7_q    <= n7_d;
      v7_q    <= v6_q;
      hpos7_q <= hpos6_q;

      v8_q <= v8_d;
      z9_q <= z9_d;
      wr_q <= wr_d;
      wg_q <= wg_d;
      wb_q <= wb_d;
      lr_q <= tr[58:43];
      lg_q <= tg[58:43];
      lb_q <= tb[58:43];
    end
  end

  // Valid bits and positions travel beside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q[0].valid <= 1'b0;
      pre_q[1].valid <= 1'b0;
      pow_req_q.ctl.valid <= 1'b0;
      for (int i = 0; i < 11; i++) begin
        post_q[i].valid <= 1'b0;
      end
    end else if (pipe_en) begin
      pre_q[0].valid <= in_i.valid;
      pre_q[0].idx   <= in_i.ramp_index;
      pre_q[1]       <= pre_q[0];
      pow_req_q.ctl  <= pre_q[1];
      pow_req_q.level <= x_d;
      post_q[0]      <= pow_rsp.ctl;
      for (int i = 1; i < 11; i++) begin
        post_q[i] <= post_q[i-1];
      end
    end
  end

  // Output register with one skid entry behind it.
  assign fire_in    = pipe_en && post_q[10].valid;
  assign last_entry = '{idx: post_q[10].idx, red: lr_q, green: lg_q, blue: lb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_o.ready) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= fire_in;
      end
    end else if (fire_in) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_o.ready) begin
      out_q <= skid_vld_q ? skid_q : last_entry;
    end else if (fire_in) begin
      skid_q <= last_entry;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.entry_index = out_q.idx;
  assign out_o.red_level   = out_q.red;
  assign out_o.green_level = out_q.green;
  assign out_o.blue_level  = out_q.blue;

  // A parked entry always has a full output register in front of it.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry without output entry");

  // While the pipeline holds, its last stage keeps its position and its red and blue levels.
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(post_q[10]) && $stable(lr_q) && $stable(lb_q))
    else $error("pipeline end changed while held");

  // A taken transfer moves the parked entry forward and frees the skid slot.
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && out_o.ready) |=> (out_vld_q && !skid_vld_q))
    else $error("skid entry not drained");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the tone curve table generator, with its own entry predictor.
`timescale 1ns / 100ps

module testbench;
  import dtc_pkg::*;

  // A finished table entry: the echoed position and the three channel levels.
  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } tone_entry_t;

  // One row of the directed part. Where known is set, the entry is typed in by hand.
  typedef struct {
    logic [IDX_W-1:0] idx;
    bit               known;
    tone_entry_t      entry;
  } ramp_row_t;

  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS  = 232;
  localparam int unsigned NUM_PHASES   = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dtc_in_if  ramp_ch ();
  dtc_out_if entry_ch ();

  display_tone_curve_lut i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_i       (ramp_ch.sink),
    .out_o      (entry_ch.source)
  );

  // The bench's own copy of the settings, indexed by register code.
  logic [CFG_DATA_W-1:0] tone_regs [8];

  tone_entry_t pending_entries [$];
  int unsigned mismatches = 0;
  int unsigned entries_checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor. It follows the fixed-point chain of the block: normalize, power
  // through log2 and exp2, shadow and highlight bends, clamp, slope and offset,
  // clamp, channel scale and rounding to a 16-bit level.
  // ---------------------------------------------------------------------------

  // Rounded division, halves away from zero.
  function automatic longint div_round(longint num, longint den);
    if (num >= 0) begin
      return (num + den / 2) / den;
    end
    return -((-num + den / 2) / den);
  endfunction

  // Raises a Q16 value in 0..1 to the reciprocal gamma; the result is Q16.
  function automatic longint power_q16(longint unsigned x);
    longint unsigned t, m, fr, neg, e, ki, ef, mant, sh;
    int unsigned msb;
    t = x;
    fr = 0;
    msb = 0;
    if (x == 0) begin
      return 0;
    end
    while (t > 1) begin
      t = t >> 1;
      msb++;
    end
    // Fraction bits of log2 come from squaring the normalized Q30 mantissa.
    m = x << (30 - msb);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd1 << 31)) begin
        fr = fr | 64'd1;
        m = m >> 1;
      end
    end
    neg = longint'(16 - msb) * 65536 - fr;
    e = (neg * longint'(tone_regs[REG_INV_GAMMA]) + 8192) >> 14;
    ki = e >> 16;
    ef = e & 64'hFFFF;
    // A very small power underflows to zero.
    if (ki > 40) begin
      return 0;
    end
    if (ef == 0) begin
      mant = 64'd1 << 30;
      sh = 14 + ki;
    end else begin
      mant = 64'd1 << 30;
      for (int k = 0; k < 16; k++) begin
        if (((65536 - ef) >> (15 - k)) & 64'd1) begin
          mant = (mant * longint'(EXP2_STEPS[k]) + (64'd1 << 29)) >> 30;
        end
      end
      sh = 15 + ki;
    end
    if (sh > 40) begin
      return 0;
    end
    return longint'((mant + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic logic [LEVEL_W-1:0] scaled_level(longint z, logic [CFG_DATA_W-1:0] scale);
    longint unsigned w;
    w = longint'(z) * longint'(scale[SCALE_W-1:0]);
    if (w > (64'd1 << 43)) begin
      w = 64'd1 << 43;
    end
    return LEVEL_W'((w * 65535 + (64'd1 << 42)) >> 43);
  endfunction

  function automatic tone_entry_t predict_entry(logic [IDX_W-1:0] idx);
    const longint one5 = longint'(5) << 30;
    const longint half_scale = longint'(1) << 31;
    longint denom, pos, x16, y, u, dark, light, s, h, v, z;
    tone_entry_t entry;
    denom = TABLE_SIZE_DEF - 1;
    pos = (idx > denom) ? denom : longint'(idx);
    x16 = (pos * 65536 + denom / 2) / denom;
    y = power_q16(x16);
    u = 65536 - y;
    dark = (u * u + 32768) >> 16;
    light = (y * y + 32768) >> 16;
    s = longint'($signed(tone_regs[REG_SHADOW]));
    h = longint'($signed(tone_regs[REG_HIGHLIGHT]));
    if (s > 0) begin
      v = y + div_round(3 * s * dark * u, one5);
    end else begin
      v = div_round(y * (one5 + 4 * s * dark), one5);
    end
    if (h > 0) begin
      v = v + div_round(h * light * (65536 - v), half_scale);
    end else begin
      v = div_round(v * (half_scale + h * light), half_scale);
    end
    if (v < 0) v = 0;
    if (v > 65536) v = 65536;
    z = longint'(tone_regs[REG_SLOPE]) * v
      + longint'($signed(tone_regs[REG_OFFSET])) * 32768;
    if (z < 0) z = 0;
    if (z > (longint'(1) << 29)) z = longint'(1) << 29;
    entry.idx   = idx;
    entry.red   = scaled_level(z, tone_regs[REG_SCALE_R]);
    entry.green = scaled_level(z, tone_regs[REG_SCALE_G]);
    entry.blue  = scaled_level(z, tone_regs[REG_SCALE_B]);
    return entry;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks. All of them are entered right after a rising edge and drive
  // with nonblocking assignments, so the block sees stable inputs at the next edge.
  // ---------------------------------------------------------------------------

  // The write enable stays high across back-to-back writes; the caller drops it.
  task automatic write_reg(cfg_reg_e which, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    tone_regs[which] = (which >= REG_SCALE_R) ? (value & 16'h7FFF) : value;
    @(posedge clk);
  endtask

  // Offers one position, with a random gap in front, and returns once it is
  // accepted. Valid stays high between back-to-back transfers.
  task automatic send_ramp(logic [IDX_W-1:0] idx, bit known, tone_entry_t typed);
    if ($urandom_range(99) < send_idle_pct) begin
      ramp_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    ramp_ch.valid      <= 1'b1;
    ramp_ch.ramp_index <= idx;
    pending_entries.insert(pending_entries.size(), known ? typed : predict_entry(idx));
    @(posedge clk);
    while (!ramp_ch.ready) @(posedge clk);
  endtask

  // Settings may only change with nothing in flight, so wait for the last entry
  // and then the full pipeline depth before touching a register.
  task automatic wait_idle();
    ramp_ch.valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready is redrawn every cycle according to the current idle share.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    entry_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Checker: each transfer on the output is compared with the oldest prediction.
  always @(posedge clk) begin
    tone_entry_t want;
    if (rst_n && entry_ch.valid && entry_ch.ready) begin
      if (pending_entries.size() == 0) begin
        report_mismatch("entry with nothing pending, index", entry_ch.entry_index, -1);
      end else begin
        want = pending_entries.pop_front();
        entries_checked++;
        if (entry_ch.entry_index !== want.idx)
          report_mismatch("entry_index", entry_ch.entry_index, want.idx);
        if (entry_ch.red_level !== want.red)
          report_mismatch("red_level", entry_ch.red_level, want.red);
        if (entry_ch.green_level !== want.green)
          report_mismatch("green_level", entry_ch.green_level, want.green);
        if (entry_ch.blue_level !== want.blue)
          report_mismatch("blue_level", entry_ch.blue_level, want.blue);
      end
    end
  end

  // Watchdog: a long stretch without any transfer on either side means a hang.
  always @(posedge clk) begin
    if ((ramp_ch.valid && ramp_ch.ready) || (entry_ch.valid && entry_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no transfer for %0d cycles, %0d entries pending", IDLE_LIMIT,
                 pending_entries.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    ramp_row_t   directed [$];
    ramp_row_t   row;
    tone_entry_t none;
    logic [CFG_DATA_W-1:0] phase_cfg [8];
    logic [IDX_W-1:0]      idx;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_INV_GAMMA;
    cfg_data           = '0;
    ramp_ch.valid      = 1'b0;
    ramp_ch.ramp_index = '0;
    send_idle_pct      = 22;
    recv_idle_pct      = 56;
    none               = '{default: '0};
    tone_regs = '{16'd16384, 16'd0, 16'd0, 16'd8192, 16'd0, 16'd16384, 16'd16384, 16'd16384};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings: the identity curve. Zero maps to
    // zero and the last position hits full scale on every channel.
    row = '{10'd0, 1'b1, '{10'd0, 16'd0, 16'd0, 16'd0}};
    directed.insert(directed.size(), row);
    row = '{10'd1023, 1'b1, '{10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF}};
    directed.insert(directed.size(), row);
    for (int i = 0; i < 14; i++) begin
      row.known = 1'b0;
      row.entry = none;
      case (i)
        0: row.idx = 10'd1;
        1: row.idx = 10'd2;
        2: row.idx = 10'd3;
        3: row.idx = 10'd511;
        4: row.idx = 10'd512;
        5: row.idx = 10'd1022;
        6: row.idx = 10'h2AA;
        7: row.idx = 10'h155;
        8: row.idx = 10'h3FE;
        9: row.idx = 10'h200;
        10: row.idx = 10'h100;
        11: row.idx = 10'h010;
        12: row.idx = 10'd4;
        default: row.idx = 10'd255;
      endcase
      directed.insert(directed.size(), row);
    end
    foreach (directed[i]) send_ramp(directed[i].idx, directed[i].known, directed[i].entry);

    // Random part: a new setting for each phase, the extremes first.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      // Idle shares: sender light and receiver heavy, then swapped, then none.
      if (ph < 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 56;
      end else if (ph < 6) begin
        send_idle_pct = 56;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        // Lowest ends of the nominal ranges.
        0: phase_cfg = '{16'd8192, -16'sd16384, -16'sd16384, 16'd0, 16'h8000,
                         16'd0, 16'd0, 16'd0};
        // Highest ends of the nominal ranges.
        1: phase_cfg = '{16'd32768, 16'd16384, 16'd16384, 16'hFFFF, 16'h7FFF,
                         16'h7FFF, 16'h7FFF, 16'h7FFF};
        // Zero inverse gamma: every nonzero position powers to full scale.
        2: phase_cfg = '{16'd0, 16'd8000, -16'sd8000, 16'd8192, 16'd0,
                         16'd16384, 16'd12000, 16'd20000};
        // Full-range bit patterns: huge exponents underflow, amounts beyond one.
        3: phase_cfg = '{16'hFFFF, 16'h7FFF, 16'h8000, 16'd9000, 16'd100,
                         16'h7FFF, 16'd1, 16'd16384};
        default: begin
          for (int r = 0; r < 8; r++) phase_cfg[r] = CFG_DATA_W'($urandom);
          phase_cfg[REG_INV_GAMMA] = CFG_DATA_W'($urandom_range(32768, 8192));
          phase_cfg[REG_SHADOW]    = CFG_DATA_W'($urandom_range(32768) - 16384);
          phase_cfg[REG_HIGHLIGHT] = CFG_DATA_W'($urandom_range(32768) - 16384);
        end
      endcase
      for (int r = 0; r < 8; r++) write_reg(cfg_reg_e'(r), phase_cfg[r]);
      cfg_we <= 1'b0;
      @(posedge clk);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 0) idx = '0;
        else if (n == 1) idx = '1;
        // Weight toward the dark end, where the power curve is steepest.
        else if ($urandom_range(3) == 0) idx = IDX_W'($urandom_range(15));
        else idx = IDX_W'($urandom);
        send_ramp(idx, 1'b0, none);
      end
    end

    wait_idle();
    $display("checked %0d table entries over %0d settings phases plus the reset curve",
             entries_checked, NUM_PHASES);
    $display("idle mixes: sender-light, receiver-light and back-to-back; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dtc_pkg.sv
rtl/dtc_in_if.sv
rtl/dtc_out_if.sv
rtl/dtc_power.sv
rtl/display_tone_curve_lut.sv
bench/testbench.sv
